### design/lca_pkg.sv
// Shared types, sizes and helper functions of the lowest common ancestor core.
`timescale 1ns / 1ps

package lca_pkg;

    localparam int NODES    = 1024;
    localparam int LEVELS   = 10;
    localparam int NODE_W   = 10;
    localparam int DEPTH_W  = 10;
    localparam int NODE_CNT = (NODES < (2 ** NODE_W)) ? NODES : (2 ** NODE_W);
    localparam int IDX_W    = $clog2(NODE_CNT);
    localparam int LVL_W    = $clog2(LEVELS);
    localparam int TAB_AW   = IDX_W + LVL_W;

    typedef logic [NODE_W-1:0]  t_node;
    typedef logic [DEPTH_W-1:0] t_depth;
    typedef logic [LVL_W-1:0]   t_lvl;
    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [TAB_AW-1:0]  t_tab_addr;

    localparam t_depth DEPTH_MAX = '1;
    localparam t_lvl   LVL_TOP   = LVL_W'(LEVELS - 1);

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    function automatic t_node node_of(input t_node v);
        return ({1'b0, v} < (NODE_W + 1)'(NODE_CNT)) ? v : '0;
    endfunction

    function automatic t_idx idx_of(input t_node v);
        return v[IDX_W-1:0];
    endfunction

endpackage

### design/lca_binary_lifting_core.sv
// Top level of the binary lifting lowest common ancestor core.
//
// Usage: the input channel carries one transaction per item: op selects a
// load (first_node added below parent second_node, 0 for a root) or a query
// (first_node, second_node). Parents must be loaded before their children.
// A load gives no result; a query gives one ancestor_node on the output channel.
// The block handles one item at a time and holds o_in_stall high while busy.
// Each ancestor level of a load needs one table read and one table write on the
// single write port. A query performs one lifting step per cycle, one read of the
// ancestor RAM per step, and ends early when the lifted node already equals the
// other node. Depths and ancestor rows live in two RAMs with two read ports each.
// After reset both channels are idle; the RAMs need no clearing pass because
// node 0 reads as zero by construction. The finished result sits in an output
// register, so the next item may be taken while it waits; when the receiver
// stalls and that register is full, a query waits before handing over its result.
`timescale 1ns / 1ps

module lca_binary_lifting_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  logic           i_op,
    input  lca_pkg::t_node i_first_node,
    input  lca_pkg::t_node i_second_node,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output lca_pkg::t_node o_ancestor_node
);

    import lca_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_W,
        S_LD_R,
        S_LD_A,
        S_Q_SW,
        S_LIFT,
        S_CMP,
        S_PAIR,
        S_FIN,
        S_FIN2,
        S_OUT
    } t_state;

    t_state    r_state;
    t_node     r_a;
    t_node     r_b;
    t_depth    r_diff;
    t_lvl      r_lvl;
    logic      r_pend;
    logic      r_out_valid;
    t_node     r_out_node;

    t_node     in_first;
    t_node     in_second;
    logic      in_accept;
    logic      out_free;

    t_depth    dep_rd_a;
    t_depth    dep_rd_b;
    t_depth    dep_a;
    t_depth    dep_b;
    logic      dep_we;
    t_depth    dep_wdata;
    logic [DEPTH_W:0] dep_inc;

    t_node     tab_rd_a;
    t_node     tab_rd_b;
    logic      tab_we;
    t_tab_addr tab_waddr;
    t_node     tab_wdata;
    t_tab_addr tab_raddr_a;
    t_tab_addr tab_raddr_b;

    t_node     pa_m;
    t_node     pb_m;
    t_node     ld_anc;
    t_node     a_one;
    t_node     a_pair;
    t_node     b_pair;
    t_depth    diff_sh;
    logic      lift_bit;
    t_lvl      lvl_nx;

    assign in_first   = node_of(i_first_node);
    assign in_second  = node_of(i_second_node);
    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid     = r_out_valid;
    assign o_ancestor_node = r_out_node;

    always_comb begin
        dep_a     = (r_a == '0) ? '0 : dep_rd_a;
        dep_b     = (r_b == '0) ? '0 : dep_rd_b;
        dep_inc   = {1'b0, dep_b} + 1'b1;
        dep_wdata = dep_inc[DEPTH_W] ? DEPTH_MAX : dep_inc[DEPTH_W-1:0];
        dep_we    = (r_state == S_LD_W);

        pa_m   = (r_a == '0) ? '0 : tab_rd_a;
        pb_m   = (r_b == '0) ? '0 : tab_rd_b;
        ld_anc = (r_b == '0) ? '0 : tab_rd_a;
        a_one  = r_pend ? pa_m : r_a;
        if (r_pend && (pa_m != pb_m)) begin
            a_pair = pa_m;
            b_pair = pb_m;
        end else begin
            a_pair = r_a;
            b_pair = r_b;
        end
        diff_sh  = r_diff >> r_lvl;
        lift_bit = diff_sh[0];
        lvl_nx   = r_lvl + 1'b1;

        tab_we    = 1'b0;
        tab_waddr = {idx_of(r_a), lvl_nx};
        tab_wdata = ld_anc;
        if (r_state == S_LD_W) begin
            tab_we    = 1'b1;
            tab_waddr = {idx_of(r_a), t_lvl'(0)};
            tab_wdata = r_b;
        end else if (r_state == S_LD_A) begin
            tab_we = 1'b1;
        end

        tab_raddr_b = {idx_of(b_pair), r_lvl};
        unique case (r_state)
            S_LIFT:  tab_raddr_a = {idx_of(a_one), r_lvl};
            S_PAIR:  tab_raddr_a = {idx_of(a_pair), r_lvl};
            S_FIN:   tab_raddr_a = {idx_of(a_pair), t_lvl'(0)};
            default: tab_raddr_a = {idx_of(r_b), r_lvl};
        endcase
    end

    lca_ram #(
        .AW (IDX_W),
        .DW (DEPTH_W)
    ) u_depth_ram (
        .i_clk     (i_clk),
        .i_we      (dep_we),
        .i_waddr   (idx_of(r_a)),
        .i_wdata   (dep_wdata),
        .i_raddr_a (idx_of(in_first)),
        .i_raddr_b (idx_of(in_second)),
        .o_rdata_a (dep_rd_a),
        .o_rdata_b (dep_rd_b)
    );

    lca_ram #(
        .AW (TAB_AW),
        .DW (NODE_W)
    ) u_anc_ram (
        .i_clk     (i_clk),
        .i_we      (tab_we),
        .i_waddr   (tab_waddr),
        .i_wdata   (tab_wdata),
        .i_raddr_a (tab_raddr_a),
        .i_raddr_b (tab_raddr_b),
        .o_rdata_a (tab_rd_a),
        .o_rdata_b (tab_rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_a    <= in_first;
                    r_b    <= in_second;
                    r_pend <= 1'b0;
                    if (in_accept) begin
                        if (t_op'(i_op) == OP_QUERY) begin
                            r_state <= S_Q_SW;
                        end else if (in_first != '0) begin
                            r_state <= S_LD_W;
                        end
                    end
                end
                S_LD_W: begin
                    r_lvl   <= '0;
                    r_state <= S_LD_R;
                end
                S_LD_R: begin
                    r_state <= S_LD_A;
                end
                S_LD_A: begin
                    r_b   <= ld_anc;
                    r_lvl <= lvl_nx;
                    if (lvl_nx == LVL_TOP) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_LD_R;
                    end
                end
                S_Q_SW: begin
                    if (dep_a < dep_b) begin
                        r_a    <= r_b;
                        r_b    <= r_a;
                        r_diff <= dep_b - dep_a;
                    end else begin
                        r_diff <= dep_a - dep_b;
                    end
                    r_pend  <= 1'b0;
                    r_lvl   <= LVL_TOP;
                    r_state <= S_LIFT;
                end
                S_LIFT: begin
                    r_a    <= a_one;
                    r_pend <= lift_bit;
                    if (r_lvl == '0) begin
                        r_state <= S_CMP;
                    end else begin
                        r_lvl <= r_lvl - 1'b1;
                    end
                end
                S_CMP: begin
                    r_a    <= a_one;
                    r_pend <= 1'b0;
                    r_lvl  <= LVL_TOP;
                    if (a_one == r_b) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_PAIR;
                    end
                end
                S_PAIR: begin
                    r_a    <= a_pair;
                    r_b    <= b_pair;
                    r_pend <= 1'b1;
                    if (r_lvl == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_lvl <= r_lvl - 1'b1;
                    end
                end
                S_FIN: begin
                    r_a     <= a_pair;
                    r_b     <= b_pair;
                    r_pend  <= 1'b0;
                    r_state <= S_FIN2;
                end
                S_FIN2: begin
                    r_a     <= pa_m;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_node  <= r_a;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### design/lca_ram.sv
// Simple dual-read, single-write synchronous RAM with registered read data.
`timescale 1ns / 1ps

module lca_ram #(
    parameter int AW = 10,
    parameter int DW = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [DW-1:0] o_rdata_a,
    output logic [DW-1:0] o_rdata_b
);

    logic [DW-1:0] r_mem [2 ** AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

### design/lca_checker.sv
// Port-level checker for the lowest common ancestor core and its bind statement.
`timescale 1ns / 1ps

module lca_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input logic           i_op,
    input lca_pkg::t_node i_first_node,
    input lca_pkg::t_node i_second_node,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input lca_pkg::t_node o_ancestor_node
);

    import lca_pkg::*;

    logic query_accept;

    assign query_accept = i_in_valid && !o_in_stall && (t_op'(i_op) == OP_QUERY);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("Core is not idle after reset.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_ancestor_node))
        else $error("Stalled result transaction changed or was dropped.");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        query_accept |=> o_in_stall ##1 o_in_stall)
        else $error("Core took a new transaction while a query was in progress.");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("Result transaction appeared without a query in progress.");

endmodule

bind lca_binary_lifting_core lca_checker u_lca_checker (.*);
